/* design/ffra_pkg.sv */
// ffra_pkg: shared types and constants of the first-fit region allocator
// used by ffra_ctrl, ffra_datapath and first_fit_region_allocator_top
package ffra_pkg;

  localparam int unsigned POOL_BYTES  = 65536;
  localparam int unsigned MAX_REGIONS = 32;
  localparam int unsigned IDX_W       = $clog2(MAX_REGIONS);
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned OFF_W       = 16;
  localparam int unsigned LEN_W       = 17;
  localparam int unsigned DCNT_W      = $clog2(LEN_W);

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_COUNT = 2'd2;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_SPACE   = 3'd1,
    ST_NOT_FOUND  = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_BAD_SIZE   = 3'd4
  } ffra_status_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [16:0] request_bytes;
    logic [15:0] region_start;
    logic [16:0] unit_bytes;
  } ffra_in_t;

  typedef struct packed {
    ffra_status_e status;
    logic [15:0]  placed_at;
    logic [16:0]  unit_count;
    logic [16:0]  free_bytes;
  } ffra_out_t;

  typedef struct packed {
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
  } ffra_entry_t;

  typedef struct packed {
    logic load;
    logic rd_idx;
    logic adv;
    logic sh_top;
    logic rd_dn;
    logic wr_dn;
    logic ins;
    logic free_hit;
    logic rd_up;
    logic wr_up;
    logic rm_end;
    logic div_start;
    logic div_step;
    logic fin;
    ffra_status_e status;
  } ffra_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       size_bad;
    logic       unit_zero;
    logic       at_end;
    logic       tail_fit;
    logic       gap_fit;
    logic       off_match;
    logic       full;
    logic       sh_at_idx;
    logic       sh_last;
    logic       div_done;
    logic       out_free;
  } ffra_sts_t;

endpackage

/* design/ffra_datapath.sv */
// ffra_datapath: sorted region table memory, scan cursor, byte counter,
// serial divider and output register; depends on ffra_pkg
module ffra_datapath import ffra_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ffra_in_t  in_data_i,
  input  ffra_cmd_t cmd_i,
  output ffra_sts_t sts_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ffra_out_t out_data_o
);

  localparam logic [17:0] Pool18 = 18'(POOL_BYTES);
  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_REGIONS);

  ffra_entry_t mem [MAX_REGIONS];
  ffra_entry_t rd_q;
  ffra_in_t    req_q;
  logic [CNT_W-1:0] cnt_q, idx_q, sh_q;
  logic [LEN_W-1:0] cursor_q, used_q;
  logic [15:0]      placed_q;
  logic [LEN_W-1:0] rem_q, quo_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic             out_valid_q;
  ffra_out_t        out_q;

  logic             wr_en, rd_en;
  logic [CNT_W-1:0] wa6, ra6;
  ffra_entry_t      wd;
  logic [17:0]      end_pos;
  logic [17:0]      trial;
  logic [LEN_W:0]   shifted;

  assign end_pos = {1'b0, cursor_q} + {1'b0, req_q.request_bytes};
  assign shifted = {rem_q, quo_q[LEN_W-1]};
  assign trial   = shifted - {1'b0, req_q.unit_bytes};

  assign wr_en = cmd_i.wr_dn | cmd_i.wr_up | cmd_i.ins;
  assign wa6   = cmd_i.ins ? idx_q : sh_q;
  assign wd    = cmd_i.ins ? {cursor_q[OFF_W-1:0], req_q.request_bytes} : rd_q;
  assign rd_en = cmd_i.rd_idx | cmd_i.rd_dn | cmd_i.rd_up;
  always_comb begin
    if (cmd_i.rd_idx) begin
      ra6 = idx_q;
    end else if (cmd_i.rd_dn) begin
      ra6 = sh_q - CNT_W'(1);
    end else begin
      ra6 = sh_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wa6[IDX_W-1:0]] <= wd;
    end
    if (rd_en) begin
      rd_q <= mem[ra6[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i;
    end
    if (cmd_i.div_start) begin
      rem_q  <= '0;
      quo_q  <= rd_q.len;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + DCNT_W'(1);
      if (!trial[17]) begin
        rem_q <= trial[LEN_W-1:0];
        quo_q <= {quo_q[LEN_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[LEN_W-1:0];
        quo_q <= {quo_q[LEN_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      idx_q    <= '0;
      sh_q     <= '0;
      cursor_q <= '0;
      used_q   <= '0;
      placed_q <= '0;
    end else begin
      if (cmd_i.load) begin
        idx_q    <= '0;
        cursor_q <= '0;
        placed_q <= '0;
      end
      if (cmd_i.adv) begin
        idx_q    <= idx_q + CNT_W'(1);
        cursor_q <= LEN_W'({1'b0, rd_q.off} + {1'b0, rd_q.len});
      end
      if (cmd_i.sh_top) begin
        sh_q <= cnt_q;
      end
      if (cmd_i.wr_dn) begin
        sh_q <= sh_q - CNT_W'(1);
      end
      if (cmd_i.wr_up) begin
        sh_q <= sh_q + CNT_W'(1);
      end
      if (cmd_i.free_hit) begin
        sh_q   <= idx_q;
        used_q <= used_q - rd_q.len;
      end
      if (cmd_i.ins) begin
        cnt_q    <= cnt_q + CNT_W'(1);
        used_q   <= used_q + req_q.request_bytes;
        placed_q <= cursor_q[15:0];
      end
      if (cmd_i.rm_end) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      out_q.status     <= cmd_i.status;
      out_q.placed_at  <= (cmd_i.status == ST_OK && req_q.kind == KIND_ALLOC) ? placed_q : '0;
      out_q.unit_count <= (cmd_i.status == ST_OK && req_q.kind == KIND_COUNT) ? quo_q : '0;
      out_q.free_bytes <= LEN_W'(Pool18 - {1'b0, used_q});
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.kind      = req_q.kind;
  assign sts_o.size_bad  = (req_q.request_bytes == '0) ||
                           ({1'b0, req_q.request_bytes} > Pool18);
  assign sts_o.unit_zero = (req_q.unit_bytes == '0);
  assign sts_o.at_end    = (idx_q == cnt_q);
  assign sts_o.tail_fit  = (end_pos <= Pool18);
  assign sts_o.gap_fit   = ({2'b0, rd_q.off} >= end_pos);
  assign sts_o.off_match = (rd_q.off == req_q.region_start);
  assign sts_o.full      = (cnt_q == MaxCnt);
  assign sts_o.sh_at_idx = (sh_q == idx_q);
  assign sts_o.sh_last   = ((sh_q + CNT_W'(1)) >= cnt_q);
  assign sts_o.div_done  = (dcnt_q == DCNT_W'(LEN_W - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt) else $error("region count above table size");
  a_used_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, used_q} <= Pool18) else $error("bytes in use above pool size");
  a_ins_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins |-> cnt_q < MaxCnt) else $error("insert into full table");
  a_fin_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin |-> (!out_valid_q || out_ready_i)) else $error("result overwritten");

endmodule

/* design/ffra_ctrl.sv */
// ffra_ctrl: sequencer for scan, insert shift, remove shift and divide
// depends on ffra_pkg; drives ffra_datapath through ffra_cmd_t
module ffra_ctrl import ffra_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ffra_sts_t sts_i,
  output ffra_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_EVAL  = 4'd3;
  localparam logic [3:0] S_SHRD  = 4'd4;
  localparam logic [3:0] S_SHWR  = 4'd5;
  localparam logic [3:0] S_INS   = 4'd6;
  localparam logic [3:0] S_RMRD  = 4'd7;
  localparam logic [3:0] S_RMWR  = 4'd8;
  localparam logic [3:0] S_RMEND = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  logic [3:0]   state_q, state_d;
  ffra_status_e st_q, st_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    cmd_o   = '0;
    cmd_o.status = st_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        state_d = S_SCAN;
        if (sts_i.kind == KIND_ALLOC) begin
          if (sts_i.size_bad) begin
            st_d    = ST_BAD_SIZE;
            state_d = S_FIN;
          end
        end else if (sts_i.kind != KIND_FREE && sts_i.kind != KIND_COUNT) begin
          st_d    = ST_BAD_SIZE;
          state_d = S_FIN;
        end
      end
      S_SCAN: begin
        if (sts_i.at_end) begin
          state_d = S_FIN;
          if (sts_i.kind != KIND_ALLOC) begin
            st_d = ST_NOT_FOUND;
          end else if (!sts_i.tail_fit) begin
            st_d = ST_NO_SPACE;
          end else if (sts_i.full) begin
            st_d = ST_TABLE_FULL;
          end else begin
            cmd_o.sh_top = 1'b1;
            state_d      = S_SHRD;
          end
        end else begin
          cmd_o.rd_idx = 1'b1;
          state_d      = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts_i.kind == KIND_ALLOC) begin
          if (sts_i.gap_fit) begin
            if (sts_i.full) begin
              st_d    = ST_TABLE_FULL;
              state_d = S_FIN;
            end else begin
              cmd_o.sh_top = 1'b1;
              state_d      = S_SHRD;
            end
          end else begin
            cmd_o.adv = 1'b1;
            state_d   = S_SCAN;
          end
        end else if (sts_i.off_match) begin
          if (sts_i.kind == KIND_FREE) begin
            cmd_o.free_hit = 1'b1;
            state_d        = S_RMRD;
          end else if (sts_i.unit_zero) begin
            st_d    = ST_BAD_SIZE;
            state_d = S_FIN;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV;
          end
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = S_SCAN;
        end
      end
      S_SHRD: begin
        if (sts_i.sh_at_idx) begin
          state_d = S_INS;
        end else begin
          cmd_o.rd_dn = 1'b1;
          state_d     = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd_o.wr_dn = 1'b1;
        state_d     = S_SHRD;
      end
      S_INS: begin
        cmd_o.ins = 1'b1;
        st_d      = ST_OK;
        state_d   = S_FIN;
      end
      S_RMRD: begin
        if (sts_i.sh_last) begin
          state_d = S_RMEND;
        end else begin
          cmd_o.rd_up = 1'b1;
          state_d     = S_RMWR;
        end
      end
      S_RMWR: begin
        cmd_o.wr_up = 1'b1;
        state_d     = S_RMRD;
      end
      S_RMEND: begin
        cmd_o.rm_end = 1'b1;
        st_d         = ST_OK;
        state_d      = S_FIN;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          st_d    = ST_OK;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  a_one_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.wr_dn, cmd_o.wr_up, cmd_o.ins}) <= 1)
    else $error("two table writes in one cycle");
  a_one_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.rd_idx, cmd_o.rd_dn, cmd_o.rd_up}) <= 1)
    else $error("two table reads in one cycle");
  a_fin_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin |=> state_q == S_IDLE) else $error("no return to idle");

endmodule

/* design/first_fit_region_allocator_top.sv */
// first_fit_region_allocator_top: request and result channels around the
// controller and datapath; depends on ffra_pkg, ffra_ctrl, ffra_datapath
//
// Requests enter on in_valid_i/in_ready_o with an ffra_in_t payload: allocate,
// free or count. Each transaction yields exactly one result transaction on
// out_valid_o/out_ready_i with an ffra_out_t payload (status, placed offset,
// unit count and free bytes after the request).
// Live regions are kept sorted by offset in a table memory with a fill
// count, so no clearing pass follows reset. A request first scans the
// offsets; an allocate then moves regions up for the insertion, a free
// moves regions down, and a count runs a bit-serial divide. The table
// memory's single read and write port sets the pace of scan and shift.
// One request is in flight at a time; in_ready_o is high whenever the
// sequencer is idle, even while a result waits in the output register.
// If the receiver stalls, the finished result holds there and the next
// request waits before its result is written. Reset empties the table
// and sets the byte count to zero.
module first_fit_region_allocator_top import ffra_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ffra_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ffra_out_t out_data_o
);

  ffra_cmd_t cmd;
  ffra_sts_t sts;

  ffra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffra_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
